[sv/itpc_pkg.sv]
// Shared types, constants and helper functions for the IPv4 text parser/classifier.
package itpc_pkg;

   // Queue between the parsing front end and the result back end
   localparam int FifoDepth    = 2;
   localparam int FifoPtrWidth = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
   localparam int FifoCntWidth = $clog2(FifoDepth + 1);

   // Grammar limits
   localparam logic [9:0] OctetMax    = 10'd255;
   localparam logic [9:0] OctetSat    = 10'd1023;
   localparam logic [2:0] PartLenMax  = 3'd3;
   localparam logic [2:0] PartLenSat  = 3'd4;
   localparam logic [2:0] LastPartIdx = 3'd3;

   // Character codes
   localparam logic [7:0] ChNul   = 8'h00;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChPlus  = 8'h2B;
   localparam logic [7:0] ChMinus = 8'h2D;
   localparam logic [7:0] ChDot   = 8'h2E;
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChNine  = 8'h39;

   // Classification boundaries on the first two octets
   localparam logic [7:0] OctPriv10      = 8'd10;
   localparam logic [7:0] OctPriv172     = 8'd172;
   localparam logic [7:0] OctPriv172Lo   = 8'd16;
   localparam logic [7:0] OctPriv172Hi   = 8'd31;
   localparam logic [7:0] OctPriv192     = 8'd192;
   localparam logic [7:0] OctPriv168     = 8'd168;
   localparam logic [7:0] OctLoopback    = 8'd127;
   localparam logic [7:0] OctMcastLo     = 8'd224;
   localparam logic [7:0] OctMcastHi     = 8'd239;
   localparam logic [7:0] OctReservedLo  = 8'd240;
   localparam logic [7:0] OctThisNet     = 8'd0;

   // Position in the dotted-quad grammar
   typedef enum logic [2:0] {
      PH_BEFORE,
      PH_START,
      PH_SIGNED,
      PH_DIGITS,
      PH_TRAIL
   } phase_type;

   typedef enum logic [2:0] {
      CLASS_PRIVATE   = 3'd0,
      CLASS_LOOPBACK  = 3'd1,
      CLASS_MULTICAST = 3'd2,
      CLASS_RESERVED  = 3'd3,
      CLASS_PUBLIC    = 3'd4
   } addr_class_type;

   // One finished text as handed from front to back
   typedef struct packed {
      logic        ok;
      logic [31:0] address;
   } rec_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == ChSpace) || (c >= ChTab && c <= ChCr);
   endfunction

   function automatic addr_class_type classify(input logic [31:0] ip);
      logic [7:0] a;
      logic [7:0] b;
      a = ip[31:24];
      b = ip[23:16];
      if (a == OctPriv10 || (a == OctPriv172 && b >= OctPriv172Lo && b <= OctPriv172Hi) ||
          (a == OctPriv192 && b == OctPriv168))
         return CLASS_PRIVATE;
      else if (a == OctLoopback)
         return CLASS_LOOPBACK;
      else if (a >= OctMcastLo && a <= OctMcastHi)
         return CLASS_MULTICAST;
      else if (a == OctThisNet || a >= OctReservedLo)
         return CLASS_RESERVED;
      else
         return CLASS_PUBLIC;
   endfunction

endpackage

[sv/itpc_if.sv]
// Valid/ready channel interfaces for the text byte input and the parse result output.
interface itpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

interface itpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [31:0] address;
   logic [2:0]  addr_class;

   modport source (output valid, output valid_res, output address, output addr_class,
                   input ready);
   modport sink   (input valid, input valid_res, input address, input addr_class,
                   output ready);
endinterface

[sv/itpc_front.sv]
// Front end: per-byte dotted-quad parser that emits one record per text.
module itpc_front
   import itpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] ch,
   input  logic       last,
   output logic       push,
   output rec_type    push_rec
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  part_count_ff, part_count_in;
   logic [2:0]  part_length_ff, part_length_in;
   logic        minus_seen_ff, minus_seen_in;
   logic [9:0]  octet_acc_ff, octet_acc_in;
   logic [31:0] addr_acc_ff, addr_acc_in;
   logic        bad_ff, bad_in;

   // Values after this byte, before the end-of-text reset
   phase_type   ph;
   logic [2:0]  pc;
   logic [2:0]  pl;
   logic        ms;
   logic [9:0]  oa;
   logic [31:0] aa;
   logic        bd;
   logic        sp;
   logic [13:0] prod;
   logic        ok;

   function automatic logic part_ok(input phase_type p, input logic [2:0] len,
                                    input logic [9:0] acc, input logic minus);
      return (p == PH_DIGITS || p == PH_TRAIL) && (len <= PartLenMax) &&
             (acc <= OctetMax) && !(minus && acc != 10'd0);
   endfunction

   assign sp = is_space(ch);

   // Byte update of the grammar state
   always_comb begin
      ph   = phase_ff;
      pc   = part_count_ff;
      pl   = part_length_ff;
      ms   = minus_seen_ff;
      oa   = octet_acc_ff;
      aa   = addr_acc_ff;
      bd   = bad_ff;
      prod = 14'd0;
      if (!(phase_ff == PH_BEFORE && sp)) begin
         if (phase_ff == PH_BEFORE) begin
            pl = 3'd0;
            ph = PH_START;
            ms = 1'b0;
            oa = 10'd0;
         end
         if (ch == ChNul) begin
            bd = 1'b1;
         end else if (ph == PH_TRAIL) begin
            if (!sp) bd = 1'b1;
         end else if (ch == ChDot) begin
            if (!part_ok(ph, pl, oa, ms) || pc >= LastPartIdx) begin
               bd = 1'b1;
            end else begin
               aa = {aa[23:0], oa[7:0]};
               pc = pc + 3'd1;
               pl = 3'd0;
               ph = PH_START;
               ms = 1'b0;
               oa = 10'd0;
            end
         end else if (sp) begin
            if (ph == PH_START) begin
               if (pl < PartLenSat) pl = pl + 3'd1;
            end else if (ph == PH_DIGITS) begin
               ph = PH_TRAIL;
            end else begin
               bd = 1'b1;
            end
         end else if (ch == ChPlus || ch == ChMinus) begin
            if (ph != PH_START) begin
               bd = 1'b1;
            end else begin
               ph = PH_SIGNED;
               ms = (ch == ChMinus);
               if (pl < PartLenSat) pl = pl + 3'd1;
            end
         end else if (ch >= ChZero && ch <= ChNine) begin
            ph = PH_DIGITS;
            if (pl < PartLenSat) pl = pl + 3'd1;
            prod = {4'd0, oa} * 14'd10 + {10'd0, 4'(ch - ChZero)};
            oa = (prod > {4'd0, OctetSat}) ? OctetSat : prod[9:0];
         end else begin
            bd = 1'b1;
         end
      end
   end

   // Next state: back to the start of a text after the last byte
   always_comb begin
      phase_in       = phase_ff;
      part_count_in  = part_count_ff;
      part_length_in = part_length_ff;
      minus_seen_in  = minus_seen_ff;
      octet_acc_in   = octet_acc_ff;
      addr_acc_in    = addr_acc_ff;
      bad_in         = bad_ff;
      if (take) begin
         if (last) begin
            phase_in       = PH_BEFORE;
            part_count_in  = 3'd0;
            part_length_in = 3'd0;
            minus_seen_in  = 1'b0;
            octet_acc_in   = 10'd0;
            addr_acc_in    = 32'd0;
            bad_in         = 1'b0;
         end else begin
            phase_in       = ph;
            part_count_in  = pc;
            part_length_in = pl;
            minus_seen_in  = ms;
            octet_acc_in   = oa;
            addr_acc_in    = aa;
            bad_in         = bd;
         end
      end
   end

   // Outputs: final verdict and address on the last byte
   always_comb begin
      ok               = !bd && (pc == LastPartIdx) && part_ok(ph, pl, oa, ms);
      push             = take && last;
      push_rec.ok      = ok;
      push_rec.address = ok ? {aa[23:0], oa[7:0]} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_BEFORE;
         part_count_ff  <= 3'd0;
         part_length_ff <= 3'd0;
         minus_seen_ff  <= 1'b0;
         octet_acc_ff   <= 10'd0;
         addr_acc_ff    <= 32'd0;
         bad_ff         <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         part_count_ff  <= part_count_in;
         part_length_ff <= part_length_in;
         minus_seen_ff  <= minus_seen_in;
         octet_acc_ff   <= octet_acc_in;
         addr_acc_ff    <= addr_acc_in;
         bad_ff         <= bad_in;
      end
   end

endmodule

[sv/itpc_fifo.sv]
// Short record queue that decouples the parser from the result stage.
module itpc_fifo
   import itpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rec_type       push_rec,
   input  logic          pop,
   output rec_type       pop_rec,
   output fifo_stat_type stat
);

   rec_type                   mem_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntWidth-1:0]   count_ff, count_in;

   function automatic logic [FifoPtrWidth-1:0] ptr_next(input logic [FifoPtrWidth-1:0] p);
      return (p == FifoPtrWidth'(FifoDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == FifoCntWidth'(FifoDepth));
   assign pop_rec    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

[sv/itpc_back.sv]
// Back end: classifies a finished record and holds it in the output register.
module itpc_back
   import itpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  fifo_stat_type stat,
   input  rec_type       pop_rec,
   output logic          pop,
   input  logic          out_ready,
   output logic          out_valid,
   output logic          out_valid_res,
   output logic [31:0]   out_address,
   output logic [2:0]    out_class
);

   logic        valid_ff, valid_in;
   logic        valid_res_ff, valid_res_in;
   logic [31:0] address_ff, address_in;
   logic [2:0]  class_ff, class_in;

   // Load the output register whenever it is empty or being drained
   assign pop = !stat.empty && (!valid_ff || out_ready);

   always_comb begin
      valid_in     = valid_ff;
      valid_res_in = valid_res_ff;
      address_in   = address_ff;
      class_in     = class_ff;
      if (pop) begin
         valid_in     = 1'b1;
         valid_res_in = pop_rec.ok;
         address_in   = pop_rec.address;
         class_in     = pop_rec.ok ? 3'(classify(pop_rec.address)) : 3'(CLASS_PRIVATE);
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      valid_res_ff <= valid_res_in;
      address_ff   <= address_in;
      class_ff     <= class_in;
   end

   assign out_valid     = valid_ff;
   assign out_valid_res = valid_res_ff;
   assign out_address   = address_ff;
   assign out_class     = class_ff;

endmodule

[sv/ipv4_text_parser_classifier_top.sv]
// Top level of the IPv4 dotted-decimal text parser and address classifier.
//
// req_chan carries the address text, one byte (ch) per transaction, with last
// set on the final byte. rsp_chan returns one transaction per text: valid_res,
// the 32-bit address (first octet in bits 31..24) and addr_class (private,
// loopback, multicast, reserved, public); address and class are zero when
// the text is malformed.
// Throughput: one byte per cycle unless the queue is full, texts back to back.
// The parser writes the finished record into the queue when it accepts the
// last byte; the output register then loads it, and the result is valid
// from that register. The record waits in the two-entry queue while the
// output is stalled.
// When rsp_chan stalls, the output register holds its transaction, the queue
// fills, and req_ready drops only once the queue is full; parsing bytes of a
// new text continues until then.
// Reset (synchronous, active high) returns the parser to the start of a text,
// empties the queue and clears the output valid.
module ipv4_text_parser_classifier_top
   import itpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   itpc_req_if.sink   req_chan,
   itpc_rsp_if.source rsp_chan
);

   logic          take;
   logic          push;
   rec_type       push_rec;
   logic          pop;
   rec_type       pop_rec;
   fifo_stat_type stat;

   assign req_chan.ready = !stat.full;
   assign take           = req_chan.valid && req_chan.ready;

   itpc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .ch       (req_chan.ch),
      .last     (req_chan.last),
      .push     (push),
      .push_rec (push_rec)
   );

   itpc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .stat     (stat)
   );

   itpc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .stat          (stat),
      .pop_rec       (pop_rec),
      .pop           (pop),
      .out_ready     (rsp_chan.ready),
      .out_valid     (rsp_chan.valid),
      .out_valid_res (rsp_chan.valid_res),
      .out_address   (rsp_chan.address),
      .out_class     (rsp_chan.addr_class)
   );

`ifndef SYNTHESIS
   // A malformed text reports all-zero payload
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.valid_res) |->
         (rsp_chan.address == 32'd0 && rsp_chan.addr_class == 3'(CLASS_PRIVATE)))
      else $error("invalid result with nonzero payload");

   // Loopback addresses are classified as such
   a_loopback: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.valid_res && rsp_chan.address[31:24] == OctLoopback) |->
         (rsp_chan.addr_class == 3'(CLASS_LOOPBACK)))
      else $error("loopback address misclassified");

   // With the pipe empty, a last byte passes through the queue and the output register to a valid output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (take && req_chan.last && stat.empty && !rsp_chan.valid) |-> ##2 rsp_chan.valid)
      else $error("result missing after last byte");

   // Queue never overflows: no push while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !push)
      else $error("record pushed into full queue");
`endif

endmodule
